// ===== rtl/du8r_pkg.sv =====
// Package for the double-encoded UTF-8 repair block.
// Holds the length cap, counter width and the byte-class constants.
// No dependencies.
`default_nettype none

package du8r_pkg;

    localparam int MAX_LEN = 65536;
    localparam int CNT_W   = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LEN - 1);

    localparam int ACC_W = 21;

    localparam logic [7:0] BYTE_C2     = 8'hC2;
    localparam logic [7:0] BYTE_C3     = 8'hC3;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_TAG   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_TAG   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_TAG   = 8'hF0;

    localparam logic [1:0] NEED_NONE  = 2'd0;
    localparam logic [1:0] NEED_ONE   = 2'd1;
    localparam logic [1:0] NEED_TWO   = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/double_utf8_repair.sv =====
// Top level of the double-encoded UTF-8 repair block.
// Depends on du8r_pkg (length cap, byte-class constants).
// Decodes a twice-encoded string byte by byte and reports if the repair applies.
`default_nettype none

// Channel   | dir | tdata                          | tuser     | tlast
// ----------+-----+--------------------------------+-----------+----------
// s_axis    | in  | [7:0] in_byte                  | -         | last
// m_axis    | out | [7:0] out_byte, [8] repaired   | has_byte  | done_res
//
// One word in, one word out. A word accepted sits in the input register (or in the
// skid register while that is held); the decode, watch and lax-check logic works
// on it and the result is registered in the output register once that slot is free.
// One word per cycle sustained while m_tready stays high.
// s_tready comes from a registered skid stage, so it does not depend on
// m_tready in the same cycle. Reset clears all valids and the string state;
// the state is cleared again after every last word.

module double_utf8_repair
    import du8r_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        s_tlast,   // last
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // [7:0] out_byte, [8] repaired, [15:9] zero
    output      logic        m_tuser,   // has_byte
    output      logic        m_tlast    // done_res
);

    // Handshake and staging registers
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             skid_valid_reg;
    logic [7:0]       skid_byte_reg;
    logic             skid_last_reg;
    logic             out_valid_reg;
    logic             out_has_reg;
    logic [7:0]       out_byte_reg;
    logic             out_done_reg;
    logic             out_rep_reg;

    // String state
    logic [7:0]       prev_byte_reg,   prev_byte_next;
    logic             moji_seen_reg,   moji_seen_next;
    logic [1:0]       decode_left_reg, decode_left_next;
    logic [ACC_W-1:0] code_accum_reg,  code_accum_next;
    logic             aborted_reg,     aborted_next;
    logic [CNT_W-1:0] out_count_reg,   out_count_next;
    logic [1:0]       check_need_reg,  check_need_next;
    logic             check_cont_reg,  check_cont_next;
    logic             check_bad_reg,   check_bad_next;

    logic             emit;
    logic [7:0]       emit_val;
    logic             rep;

    logic             accept;
    logic             advance;
    logic             in_free;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    // Move the held word into the output register when that slot is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign in_free  = !in_valid_reg || advance;

    // Input register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
            begin
                if (skid_valid_reg)
                begin
                    in_valid_reg   <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    in_valid_reg <= accept;
                end
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free)
        begin
            if (skid_valid_reg)
            begin
                in_byte_reg <= skid_byte_reg;
                in_last_reg <= skid_last_reg;
            end
            else if (accept)
            begin
                in_byte_reg <= s_tdata;
                in_last_reg <= s_tlast;
            end
        end
        if (!in_free && accept)
        begin
            skid_byte_reg <= s_tdata;
            skid_last_reg <= s_tlast;
        end
    end

    // Decode, double-encoding watch and lax check for the held word
    always_comb
    begin
        logic       complete;
        logic [7:0] b;
        logic       lst;

        b        = in_byte_reg;
        lst      = in_last_reg;
        complete = 1'b0;
        emit     = 1'b0;
        emit_val = 8'd0;
        rep      = 1'b0;

        moji_seen_next = moji_seen_reg
                       | (((prev_byte_reg == BYTE_C3) || (prev_byte_reg == BYTE_C2))
                          && ((b & CONT_MASK) == CONT_TAG));
        prev_byte_next   = b;
        decode_left_next = decode_left_reg;
        code_accum_next  = code_accum_reg;
        aborted_next     = aborted_reg;
        out_count_next   = out_count_reg;
        check_need_next  = check_need_reg;
        check_cont_next  = check_cont_reg;
        check_bad_next   = check_bad_reg;

        if (!aborted_reg)
        begin
            if (decode_left_reg != NEED_NONE)
            begin
                // Continuation taken on trust: append its low six bits
                code_accum_next  = {code_accum_reg[ACC_W-7:0], b[5:0]};
                decode_left_next = decode_left_reg - 2'd1;
                complete         = (decode_left_next == NEED_NONE);
            end
            else if (out_count_reg < CNT_LIMIT)
            begin
                if (!b[7])
                begin
                    emit     = 1'b1;
                    emit_val = b;
                end
                else if ((b & LEAD2_MASK) == LEAD2_TAG)
                begin
                    code_accum_next  = {16'd0, b[4:0]};
                    decode_left_next = NEED_ONE;
                end
                else if ((b & LEAD3_MASK) == LEAD3_TAG)
                begin
                    code_accum_next  = {17'd0, b[3:0]};
                    decode_left_next = NEED_TWO;
                end
                else if ((b & LEAD4_MASK) == LEAD4_TAG)
                begin
                    code_accum_next  = {18'd0, b[2:0]};
                    decode_left_next = NEED_THREE;
                end
                else
                begin
                    // Not a lead byte: copy raw
                    emit     = 1'b1;
                    emit_val = b;
                end
            end

            // String ends inside a sequence: pad the missing bits with zeros
            if (lst && (decode_left_next != NEED_NONE))
            begin
                case (decode_left_next)
                    NEED_ONE:   code_accum_next = {code_accum_next[ACC_W-7:0], 6'd0};
                    NEED_TWO:   code_accum_next = {code_accum_next[ACC_W-13:0], 12'd0};
                    NEED_THREE: code_accum_next = {code_accum_next[ACC_W-19:0], 18'd0};
                    default:    code_accum_next = code_accum_next;
                endcase
                decode_left_next = NEED_NONE;
                complete         = 1'b1;
            end

            if (complete)
            begin
                if (code_accum_next[ACC_W-1:8] == '0)
                begin
                    emit     = 1'b1;
                    emit_val = code_accum_next[7:0];
                end
                else
                begin
                    aborted_next = 1'b1;
                end
            end
        end

        if (emit)
        begin
            out_count_next = out_count_reg + CNT_W'(1);
            // Lax UTF-8 check on the repaired byte
            if (check_need_reg != NEED_NONE)
            begin
                if (check_cont_reg && ((emit_val & CONT_MASK) != CONT_TAG))
                begin
                    check_bad_next = 1'b1;
                end
                check_need_next = check_need_reg - 2'd1;
                check_cont_next = 1'b0;
            end
            else if (!emit_val[7])
            begin
                check_need_next = NEED_NONE;
            end
            else if ((emit_val & LEAD2_MASK) == LEAD2_TAG)
            begin
                check_need_next = NEED_ONE;
                check_cont_next = 1'b1;
            end
            else if ((emit_val & LEAD3_MASK) == LEAD3_TAG)
            begin
                check_need_next = NEED_TWO;
            end
            else if ((emit_val & LEAD4_MASK) == LEAD4_TAG)
            begin
                check_need_next = NEED_THREE;
            end
            else
            begin
                check_bad_next = 1'b1;
            end
        end

        if (lst)
        begin
            rep = moji_seen_next && !aborted_next && !check_bad_next
                  && (check_need_next == NEED_NONE);
            // Drop all string state for the next string
            prev_byte_next   = 8'd0;
            moji_seen_next   = 1'b0;
            decode_left_next = NEED_NONE;
            code_accum_next  = '0;
            aborted_next     = 1'b0;
            out_count_next   = '0;
            check_need_next  = NEED_NONE;
            check_cont_next  = 1'b0;
            check_bad_next   = 1'b0;
        end
    end

    // String state, advanced once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_byte_reg   <= 8'd0;
            moji_seen_reg   <= 1'b0;
            decode_left_reg <= NEED_NONE;
            code_accum_reg  <= '0;
            aborted_reg     <= 1'b0;
            out_count_reg   <= '0;
            check_need_reg  <= NEED_NONE;
            check_cont_reg  <= 1'b0;
            check_bad_reg   <= 1'b0;
        end
        else if (advance)
        begin
            prev_byte_reg   <= prev_byte_next;
            moji_seen_reg   <= moji_seen_next;
            decode_left_reg <= decode_left_next;
            code_accum_reg  <= code_accum_next;
            aborted_reg     <= aborted_next;
            out_count_reg   <= out_count_next;
            check_need_reg  <= check_need_next;
            check_cont_reg  <= check_cont_next;
            check_bad_reg   <= check_bad_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_has_reg  <= emit;
            out_byte_reg <= emit_val;
            out_done_reg <= in_last_reg;
            out_rep_reg  <= rep;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_rep_reg, out_byte_reg};
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_done_reg;

endmodule

`default_nettype wire
